// File: sv/ddtrie_pkg.sv
// Types and constants of the decimal digit trie insert and find unit.
`default_nettype none
package ddtrie_pkg;

	localparam int unsigned RADIX      = 10;
	localparam int unsigned MAX_DIGITS = 10;
	localparam int unsigned KEY_W      = 32;
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned BCD_W      = 4 * MAX_DIGITS;
	localparam int unsigned DIGIT_IW   = $clog2(MAX_DIGITS);
	localparam int unsigned CONV_CW    = $clog2(KEY_W);
	localparam int unsigned OUT_W      = 2 + 3 * CNT_W;
	localparam int unsigned OUT_TW     = ((OUT_W + 7) / 8) * 8;

	localparam logic       REQ_INSERT  = 1'b0;
	localparam logic       REQ_FIND    = 1'b1;
	localparam logic       STATUS_OK   = 1'b0;
	localparam logic       STATUS_FULL = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CONV,
		ST_LOOK,
		ST_CHECK,
		ST_MARK_RD,
		ST_MARK_CHK,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// File: sv/decimal_digit_trie_insert_find_unit.sv
// Top level of the decimal digit trie insert and find unit.
//
// Stores 32-bit keys in a trie over their decimal digits (most significant first, no leading
// zeros) in a pool of NODE_COUNT nodes, root at node zero. A beat on s_* with tuser 0 inserts
// the key, with tuser 1 looks it up; each request yields one result beat on m_* carrying
// found, status (pool full) and the saturating counts of distinct keys, hits and misses.
// After reset the unit runs a clearing pass over the link and end mark memories and accepts
// no request meanwhile. One request at a time: a request converts its key, then walks its d
// digits (1 to 10); a find that misses a link or an insert that meets a full pool stops at that
// digit and skips the end mark read. The binary to decimal converter retires one key bit per
// cycle, and each digit costs a read of the single-port-read link memory plus a decision in
// ST_CHECK. The next request is taken while the previous result still waits in the output
// register; a result finds that register still full only if m_tready stays low, and then
// waits there.
`default_nettype none
module decimal_digit_trie_insert_find_unit #(
	parameter int unsigned NODE_COUNT = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// [31:0] key
	input  wire logic [ddtrie_pkg::KEY_W-1:0]    s_tdata,
	// [0] req_type
	input  wire logic [0:0]                      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [0] found, [1] status, [33:2] distinct_keys, [65:34] hit_count, [97:66] miss_count,
	// [103:98] zero
	output logic [ddtrie_pkg::OUT_TW-1:0]        m_tdata
);

	localparam int unsigned NW    = $clog2(NODE_COUNT);
	localparam int unsigned FW    = NW + 1;
	localparam int unsigned SLOTS = NODE_COUNT * ddtrie_pkg::RADIX;
	localparam int unsigned SW    = $clog2(SLOTS);

	ddtrie_pkg::state_t state_q, state_d;

	logic [SW-1:0]                       clr_q;
	logic [ddtrie_pkg::KEY_W-1:0]        bin_q;
	logic [ddtrie_pkg::BCD_W-1:0]        bcd_q;
	logic [ddtrie_pkg::CONV_CW-1:0]      conv_cnt_q;
	logic [ddtrie_pkg::DIGIT_IW-1:0]     idx_q;
	logic [NW-1:0]                       node_q;
	logic [FW-1:0]                       free_q;
	logic                                is_find_q;
	logic                                found_q;
	logic                                status_q;
	logic [ddtrie_pkg::CNT_W-1:0]        key_total_q;
	logic [ddtrie_pkg::CNT_W-1:0]        hit_total_q;
	logic [ddtrie_pkg::CNT_W-1:0]        miss_total_q;
	logic                                m_tvalid_q;
	logic [ddtrie_pkg::OUT_TW-1:0]       m_tdata_q;

	logic [NW-1:0] link_mem [SLOTS];
	logic          mark_mem [NODE_COUNT];
	logic [NW-1:0] link_rd_q;
	logic          mark_rd_q;

	logic          link_we;
	logic [SW-1:0] link_waddr;
	logic [NW-1:0] link_wdata;
	logic [SW-1:0] link_raddr;
	logic          mark_we;
	logic [NW-1:0] mark_waddr;
	logic          mark_wdata;
	logic [NW-1:0] mark_raddr;

	logic [ddtrie_pkg::BCD_W-1:0]    bcd_adj;
	logic [ddtrie_pkg::BCD_W-1:0]    bcd_next;
	logic [ddtrie_pkg::DIGIT_IW-1:0] top_idx;
	logic [3:0]                      digit;
	logic [SW-1:0]                   slot;
	logic                            pool_ok;
	logic                            step_ok;
	logic                            out_free;

	// add-3 correction and shift of the converter
	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < ddtrie_pkg::MAX_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
		bcd_next = {bcd_adj[ddtrie_pkg::BCD_W-2:0], bin_q[ddtrie_pkg::KEY_W-1]};
	end

	always_comb begin
		top_idx = '0;
		for (int i = 0; i < ddtrie_pkg::MAX_DIGITS; i++) begin
			if (bcd_next[4*i +: 4] != 4'd0) begin
				top_idx = ddtrie_pkg::DIGIT_IW'(i);
			end
		end
	end

	assign digit    = bcd_q[{idx_q, 2'b00} +: 4];
	assign slot     = SW'({node_q, 3'b000}) + SW'({node_q, 1'b0}) + SW'(digit);
	assign pool_ok  = free_q < FW'(NODE_COUNT);
	assign step_ok  = (link_rd_q != '0) || (!is_find_q && pool_ok);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ddtrie_pkg::ST_CLEAR: begin
				if (clr_q == SW'(SLOTS - 1)) begin
					state_d = ddtrie_pkg::ST_IDLE;
				end
			end
			ddtrie_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ddtrie_pkg::ST_CONV;
				end
			end
			ddtrie_pkg::ST_CONV: begin
				if (conv_cnt_q == '1) begin
					state_d = ddtrie_pkg::ST_LOOK;
				end
			end
			ddtrie_pkg::ST_LOOK: state_d = ddtrie_pkg::ST_CHECK;
			ddtrie_pkg::ST_CHECK: begin
				if (!step_ok) begin
					state_d = ddtrie_pkg::ST_DONE;
				end else if (idx_q == '0) begin
					state_d = ddtrie_pkg::ST_MARK_RD;
				end else begin
					state_d = ddtrie_pkg::ST_LOOK;
				end
			end
			ddtrie_pkg::ST_MARK_RD:  state_d = ddtrie_pkg::ST_MARK_CHK;
			ddtrie_pkg::ST_MARK_CHK: state_d = ddtrie_pkg::ST_DONE;
			ddtrie_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = ddtrie_pkg::ST_IDLE;
				end
			end
			default: state_d = ddtrie_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		link_we    = 1'b0;
		link_waddr = slot;
		link_wdata = free_q[NW-1:0];
		link_raddr = slot;
		mark_we    = 1'b0;
		mark_waddr = node_q;
		mark_wdata = 1'b1;
		mark_raddr = node_q;
		s_tready   = 1'b0;
		case (state_q)
			ddtrie_pkg::ST_CLEAR: begin
				link_we    = 1'b1;
				link_waddr = clr_q;
				link_wdata = '0;
				mark_we    = clr_q < SW'(NODE_COUNT);
				mark_waddr = clr_q[NW-1:0];
				mark_wdata = 1'b0;
			end
			ddtrie_pkg::ST_IDLE: s_tready = 1'b1;
			ddtrie_pkg::ST_CHECK: begin
				link_we = (link_rd_q == '0) && !is_find_q && pool_ok;
			end
			ddtrie_pkg::ST_MARK_CHK: begin
				mark_we = !is_find_q && !mark_rd_q;
			end
			default: begin
				link_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		link_rd_q <= link_mem[link_raddr];
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_waddr] <= mark_wdata;
		end
		mark_rd_q <= mark_mem[mark_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ddtrie_pkg::ST_CLEAR;
			clr_q        <= '0;
			free_q       <= FW'(1);
			key_total_q  <= '0;
			hit_total_q  <= '0;
			miss_total_q <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ddtrie_pkg::ST_CLEAR) begin
				clr_q <= clr_q + SW'(1);
			end
			if (link_we && state_q == ddtrie_pkg::ST_CHECK) begin
				free_q <= free_q + FW'(1);
			end
			if (state_q == ddtrie_pkg::ST_CHECK && !step_ok && is_find_q &&
					miss_total_q != ddtrie_pkg::COUNT_MAX) begin
				miss_total_q <= miss_total_q + ddtrie_pkg::CNT_W'(1);
			end
			if (state_q == ddtrie_pkg::ST_MARK_CHK) begin
				if (is_find_q) begin
					if (mark_rd_q) begin
						if (hit_total_q != ddtrie_pkg::COUNT_MAX) begin
							hit_total_q <= hit_total_q + ddtrie_pkg::CNT_W'(1);
						end
					end else if (miss_total_q != ddtrie_pkg::COUNT_MAX) begin
						miss_total_q <= miss_total_q + ddtrie_pkg::CNT_W'(1);
					end
				end else if (!mark_rd_q && key_total_q != ddtrie_pkg::COUNT_MAX) begin
					key_total_q <= key_total_q + ddtrie_pkg::CNT_W'(1);
				end
			end
			if (state_q == ddtrie_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ddtrie_pkg::ST_IDLE: begin
				bin_q      <= s_tdata;
				bcd_q      <= '0;
				conv_cnt_q <= '0;
				node_q     <= '0;
				is_find_q  <= (s_tuser[0] == ddtrie_pkg::REQ_FIND);
				found_q    <= 1'b0;
				status_q   <= ddtrie_pkg::STATUS_OK;
			end
			ddtrie_pkg::ST_CONV: begin
				bcd_q      <= bcd_next;
				bin_q      <= {bin_q[ddtrie_pkg::KEY_W-2:0], 1'b0};
				conv_cnt_q <= conv_cnt_q + ddtrie_pkg::CONV_CW'(1);
				idx_q      <= top_idx;
			end
			ddtrie_pkg::ST_CHECK: begin
				if (!step_ok) begin
					status_q <= is_find_q ? ddtrie_pkg::STATUS_OK : ddtrie_pkg::STATUS_FULL;
				end else begin
					node_q <= (link_rd_q != '0) ? link_rd_q : free_q[NW-1:0];
					idx_q  <= idx_q - ddtrie_pkg::DIGIT_IW'(1);
				end
			end
			ddtrie_pkg::ST_MARK_CHK: found_q <= mark_rd_q;
			ddtrie_pkg::ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= ddtrie_pkg::OUT_TW'({miss_total_q, hit_total_q, key_total_q,
						status_q, found_q});
				end
			end
			default: begin
				bin_q <= bin_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

// File: test/tb_decimal_digit_trie_insert_find_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of the decimal digit trie insert and find unit.
module tb_decimal_digit_trie_insert_find_unit;

	localparam int unsigned NODES        = 1024;
	localparam int unsigned TRIE_LATENCY = 60;
	localparam int unsigned RANDOM_REQS  = 1576;

	typedef struct packed {
		logic                        found;
		logic                        status;
		logic [ddtrie_pkg::CNT_W-1:0] keys;
		logic [ddtrie_pkg::CNT_W-1:0] hits;
		logic [ddtrie_pkg::CNT_W-1:0] misses;
	} trie_result_t;

	typedef struct packed {
		logic                        req;
		logic [ddtrie_pkg::KEY_W-1:0] key;
		logic                        typed;
		trie_result_t                res;
	} dir_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [ddtrie_pkg::KEY_W-1:0]  s_tdata;
	logic [0:0]                    s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [ddtrie_pkg::OUT_TW-1:0] m_tdata;

	int unsigned                  link_mem [NODES*ddtrie_pkg::RADIX];
	bit                           mark_mem [NODES];
	int unsigned                  next_node;
	logic [ddtrie_pkg::CNT_W-1:0] key_total;
	logic [ddtrie_pkg::CNT_W-1:0] hit_total;
	logic [ddtrie_pkg::CNT_W-1:0] miss_total;

	trie_result_t                 pending_q [$];
	dir_row_t                     dir_rows [$];
	logic [ddtrie_pkg::KEY_W-1:0] known_keys [$];
	int unsigned                  err_count;
	bit                           no_idle;

	decimal_digit_trie_insert_find_unit #(
		.NODE_COUNT(NODES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic trie_result_t predict_request(logic req,
			logic [ddtrie_pkg::KEY_W-1:0] key);
		int unsigned  digits [ddtrie_pkg::MAX_DIGITS];
		int unsigned  rev [ddtrie_pkg::MAX_DIGITS];
		int           n;
		int unsigned  k;
		int unsigned  node;
		int unsigned  nxt;
		int unsigned  slot;
		bit           walked;
		trie_result_t r;
		k = key;
		n = 0;
		do begin
			rev[n] = k % ddtrie_pkg::RADIX;
			k = k / ddtrie_pkg::RADIX;
			n++;
		end while (k != 0 && n < ddtrie_pkg::MAX_DIGITS);
		for (int i = 0; i < n; i++)
			digits[i] = rev[n-1-i];
		node = 0;
		walked = 1'b1;
		r = '0;
		r.status = ddtrie_pkg::STATUS_OK;
		for (int i = 0; i < n; i++) begin
			slot = node * ddtrie_pkg::RADIX + digits[i];
			nxt = link_mem[slot];
			if (nxt == 0) begin
				if (req == ddtrie_pkg::REQ_FIND) begin
					walked = 1'b0;
					break;
				end
				if (next_node >= NODES) begin
					r.status = ddtrie_pkg::STATUS_FULL;
					walked = 1'b0;
					break;
				end
				nxt = next_node;
				next_node++;
				link_mem[slot] = nxt;
			end
			node = nxt;
		end
		if (req == ddtrie_pkg::REQ_FIND) begin
			if (walked && mark_mem[node]) begin
				r.found = 1'b1;
				if (hit_total != ddtrie_pkg::COUNT_MAX)
					hit_total++;
			end else if (miss_total != ddtrie_pkg::COUNT_MAX) begin
				miss_total++;
			end
		end else if (walked) begin
			if (mark_mem[node]) begin
				r.found = 1'b1;
			end else begin
				mark_mem[node] = 1'b1;
				if (key_total != ddtrie_pkg::COUNT_MAX)
					key_total++;
			end
		end
		r.keys = key_total;
		r.hits = hit_total;
		r.misses = miss_total;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [ddtrie_pkg::CNT_W-1:0] got,
			input logic [ddtrie_pkg::CNT_W-1:0] want);
		$display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		err_count++;
	endtask

	task automatic add_row(input logic req, input logic [ddtrie_pkg::KEY_W-1:0] key,
			input logic typed, input logic found, input logic status,
			input logic [ddtrie_pkg::CNT_W-1:0] keys, input logic [ddtrie_pkg::CNT_W-1:0] hits,
			input logic [ddtrie_pkg::CNT_W-1:0] misses);
		dir_row_t row;
		row.req = req;
		row.key = key;
		row.typed = typed;
		row.res.found = found;
		row.res.status = status;
		row.res.keys = keys;
		row.res.hits = hits;
		row.res.misses = misses;
		dir_rows.push_back(row);
	endtask

	// Call at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_request(input logic req, input logic [ddtrie_pkg::KEY_W-1:0] key,
			input logic typed, input trie_result_t typed_res);
		trie_result_t r;
		while (!no_idle && $urandom_range(0, 99) < 14) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= key;
		do @(posedge clk); while (!s_tready);
		r = predict_request(req, key);
		pending_q.push_back(typed ? typed_res : r);
		if (req == ddtrie_pkg::REQ_INSERT)
			known_keys.push_back(key);
		@(negedge clk);
	endtask

	function automatic logic [ddtrie_pkg::KEY_W-1:0] pick_known();
		logic [ddtrie_pkg::KEY_W-1:0] k;
		k = known_keys[$urandom_range(0, known_keys.size() - 1)];
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 9)) k = k / ddtrie_pkg::RADIX;
		return k;
	endfunction

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= no_idle || $urandom_range(0, 99) >= 14;
		end
	end

	always @(posedge clk) begin : check_results
		trie_result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				report_mismatch("beat with nothing pending", m_tdata[2 +: ddtrie_pkg::CNT_W],
					'0);
			end else begin
				want = pending_q.pop_front();
				if (m_tdata[0] !== want.found)
					report_mismatch("found", ddtrie_pkg::CNT_W'(m_tdata[0]),
						ddtrie_pkg::CNT_W'(want.found));
				if (m_tdata[1] !== want.status)
					report_mismatch("status", ddtrie_pkg::CNT_W'(m_tdata[1]),
						ddtrie_pkg::CNT_W'(want.status));
				if (m_tdata[2 +: ddtrie_pkg::CNT_W] !== want.keys)
					report_mismatch("distinct_keys", m_tdata[2 +: ddtrie_pkg::CNT_W],
						want.keys);
				if (m_tdata[2+ddtrie_pkg::CNT_W +: ddtrie_pkg::CNT_W] !== want.hits)
					report_mismatch("hit_count",
						m_tdata[2+ddtrie_pkg::CNT_W +: ddtrie_pkg::CNT_W], want.hits);
				if (m_tdata[2+2*ddtrie_pkg::CNT_W +: ddtrie_pkg::CNT_W] !== want.misses)
					report_mismatch("miss_count",
						m_tdata[2+2*ddtrie_pkg::CNT_W +: ddtrie_pkg::CNT_W], want.misses);
			end
		end
	end

	initial begin
		logic                         req;
		logic [ddtrie_pkg::KEY_W-1:0] key;
		int unsigned                  sel;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		no_idle = 1'b0;
		err_count = 0;
		next_node = 1;
		key_total = '0;
		hit_total = '0;
		miss_total = '0;

		// found, status, keys, hits, misses after each request
		add_row(ddtrie_pkg::REQ_FIND,   32'd0,          1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 0, 0, 1);
		add_row(ddtrie_pkg::REQ_INSERT, 32'd0,          1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 1, 0, 1);
		add_row(ddtrie_pkg::REQ_FIND,   32'd0,          1'b1, 1'b1, ddtrie_pkg::STATUS_OK, 1, 1, 1);
		add_row(ddtrie_pkg::REQ_INSERT, 32'd0,          1'b1, 1'b1, ddtrie_pkg::STATUS_OK, 1, 1, 1);
		add_row(ddtrie_pkg::REQ_INSERT, 32'hFFFFFFFF,   1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 2, 1, 1);
		add_row(ddtrie_pkg::REQ_FIND,   32'hFFFFFFFF,   1'b1, 1'b1, ddtrie_pkg::STATUS_OK, 2, 2, 1);
		add_row(ddtrie_pkg::REQ_FIND,   32'd429496729,  1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 2, 2, 2);
		add_row(ddtrie_pkg::REQ_INSERT, 32'd429496729,  1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 3, 2, 2);
		add_row(ddtrie_pkg::REQ_FIND,   32'd429496729,  1'b1, 1'b1, ddtrie_pkg::STATUS_OK, 3, 3, 2);
		add_row(ddtrie_pkg::REQ_FIND,   32'd4,          1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 3, 3, 3);
		add_row(ddtrie_pkg::REQ_INSERT, 32'd4,          1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 4, 3, 3);
		add_row(ddtrie_pkg::REQ_INSERT, 32'd1000000000, 1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 5, 3, 3);
		add_row(ddtrie_pkg::REQ_FIND,   32'd100000000,  1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 5, 3, 4);
		add_row(ddtrie_pkg::REQ_INSERT, 32'd9,          1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 6, 3, 4);
		add_row(ddtrie_pkg::REQ_FIND,   32'd90,         1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 6, 3, 5);
		add_row(ddtrie_pkg::REQ_INSERT, 32'h80000000,   1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 7, 3, 5);
		add_row(ddtrie_pkg::REQ_FIND,   32'h7FFFFFFF,   1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 7, 3, 6);
		add_row(ddtrie_pkg::REQ_FIND,   32'h80000000,   1'b1, 1'b1, ddtrie_pkg::STATUS_OK, 7, 4, 6);
		add_row(ddtrie_pkg::REQ_INSERT, 32'd10,         1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 8, 4, 6);
		add_row(ddtrie_pkg::REQ_FIND,   32'd1,          1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 8, 4, 7);
		add_row(ddtrie_pkg::REQ_INSERT, 32'd1,          1'b1, 1'b0, ddtrie_pkg::STATUS_OK, 9, 4, 7);
		add_row(ddtrie_pkg::REQ_FIND,   32'd1,          1'b1, 1'b1, ddtrie_pkg::STATUS_OK, 9, 5, 7);
		add_row(ddtrie_pkg::REQ_INSERT, 32'd123456789,  1'b0, 1'b0, ddtrie_pkg::STATUS_OK, 0, 0, 0);
		add_row(ddtrie_pkg::REQ_FIND,   32'd12345,      1'b0, 1'b0, ddtrie_pkg::STATUS_OK, 0, 0, 0);
		add_row(ddtrie_pkg::REQ_INSERT, 32'hFFFFFFFE,   1'b0, 1'b0, ddtrie_pkg::STATUS_OK, 0, 0, 0);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_request(dir_rows[i].req, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].res);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			no_idle = (i >= 600 && i < 800);
			sel = $urandom_range(0, 99);
			if (sel < 30) begin
				req = ddtrie_pkg::REQ_INSERT;
				key = $urandom_range(0, 999);
			end else if (sel < 50) begin
				req = ddtrie_pkg::REQ_INSERT;
				key = $urandom();
			end else if (sel < 60) begin
				req = ddtrie_pkg::REQ_INSERT;
				key = pick_known();
			end else if (sel < 85) begin
				req = ddtrie_pkg::REQ_FIND;
				key = pick_known();
			end else begin
				req = ddtrie_pkg::REQ_FIND;
				key = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 999);
			end
			send_request(req, key, 1'b0, '0);
		end
		s_tvalid <= 1'b0;
		no_idle = 1'b0;

		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (TRIE_LATENCY) @(posedge clk);
		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
